[rtl/mpus_pkg.sv]
// ----------------------------------------------------------------------------
// Modem power-up sequencer package
// Field widths, register indexes, power action codes and delay constants
// shared by the result interface and the sequencer.
// ----------------------------------------------------------------------------
package mpus_pkg;

    localparam int unsigned SUBSTATE_W = 3;
    localparam int unsigned POWER_W    = 2;
    localparam int unsigned DELAY_W    = 10;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned TRIES_W    = 4;
    localparam int unsigned SECS_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [SUBSTATE_W-1:0] t_substate;
    typedef logic [POWER_W-1:0]    t_power;
    typedef logic [DELAY_W-1:0]    t_delay;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [TRIES_W-1:0]    t_tries;
    typedef logic [SECS_W-1:0]     t_secs;

    // Power action codes.
    localparam t_power PWR_NONE = 2'd0;
    localparam t_power PWR_OFF  = 2'd1;
    localparam t_power PWR_ON   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HARD_TRIES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_TRIES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_CYCLE_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_WAIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_WAIT   = 3'd5;

    // Register reset values.
    localparam t_tries RST_HARD_TRIES     = 4'd3;
    localparam t_tries RST_TOGGLE_TRIES   = 4'd3;
    localparam t_count RST_NEW_CYCLE_WAIT = 16'd900;
    localparam t_secs  RST_SETTLE         = 8'd5;
    localparam t_secs  RST_TOGGLE_WAIT    = 8'd10;
    localparam t_secs  RST_SERVICE_WAIT   = 8'd60;

    // Step delays in milliseconds.
    localparam t_delay DELAY_NONE  = 10'd0;
    localparam t_delay DELAY_PULSE = 10'd500;
    localparam t_delay DELAY_TICK  = 10'd1000;

endpackage

[rtl/mpus_in_if.sv]
// ----------------------------------------------------------------------------
// Sequencer step channel
// Valid/ready channel carrying the three flags of one scheduler step.
// ----------------------------------------------------------------------------
interface mpus_in_if;

    logic valid;
    logic ready;
    logic reload_request;
    logic service_mode;
    logic at_reply_ok;

    modport source (output valid, output reload_request, output service_mode,
                    output at_reply_ok, input ready);
    modport sink   (input valid, input reload_request, input service_mode,
                    input at_reply_ok, output ready);

endinterface

[rtl/mpus_out_if.sv]
// ----------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel carrying the actions decided for one scheduler step.
// ----------------------------------------------------------------------------
interface mpus_out_if
    import mpus_pkg::*;
;

    logic      valid;
    logic      ready;
    t_substate next_substate;
    t_power    power_action;
    logic      switch_pulse;
    logic      send_probe;
    logic      clear_link_info;
    logic      reload_strobe;
    logic      online_handover;
    t_delay    delay_ms;

    modport source (output valid, output next_substate, output power_action,
                    output switch_pulse, output send_probe, output clear_link_info,
                    output reload_strobe, output online_handover, output delay_ms,
                    input ready);
    modport sink   (input valid, input next_substate, input power_action,
                    input switch_pulse, input send_probe, input clear_link_info,
                    input reload_strobe, input online_handover, input delay_ms,
                    output ready);

endinterface

[rtl/modem_power_up_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Modem power-up sequencer
// Eight-substate machine that power-cycles a modem, toggles its switch pin
// and probes it with AT until it answers, with retry and long-wait fallback.
// ----------------------------------------------------------------------------
// Each step transaction on i_in yields exactly one result transaction on
// o_out. The block takes one step per clock cycle while o_out is not
// stalled: a step is captured in an input register, decided by one short
// level of logic against the sequencer state, and stored in a result
// register, which drives o_out; a step stays in the input register while
// the result register still holds a result for o_out. While a result
// waits for o_out.ready, one more step is still taken into the input
// register; only when both registers are full does i_in.ready drop.
// Configuration writes take effect at the clock edge where i_cfg_we is high
// and must be issued only while no step is in flight.
module modem_power_up_sequencer_unit
    import mpus_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mpus_in_if.sink               i_in,
    mpus_out_if.source            o_out
);

    // Substate codes.
    localparam t_substate ST_INIT        = 3'd0;
    localparam t_substate ST_DECIDE      = 3'd1;
    localparam t_substate ST_AFTER_OFF   = 3'd2;
    localparam t_substate ST_AFTER_ON    = 3'd3;
    localparam t_substate ST_TOGGLE      = 3'd4;
    localparam t_substate ST_AFTER_TOGGLE = 3'd5;
    localparam t_substate ST_EVALUATE    = 3'd6;
    localparam t_substate ST_LONG_WAIT   = 3'd7;

    // Configuration registers.
    t_tries r_hard_tries;
    t_tries r_toggle_tries;
    t_count r_new_cycle_wait;
    t_secs  r_settle;
    t_secs  r_toggle_wait;
    t_secs  r_service_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard_tries     <= RST_HARD_TRIES;
            r_toggle_tries   <= RST_TOGGLE_TRIES;
            r_new_cycle_wait <= RST_NEW_CYCLE_WAIT;
            r_settle         <= RST_SETTLE;
            r_toggle_wait    <= RST_TOGGLE_WAIT;
            r_service_wait   <= RST_SERVICE_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HARD_TRIES:     r_hard_tries     <= i_cfg_data[TRIES_W-1:0];
                REG_TOGGLE_TRIES:   r_toggle_tries   <= i_cfg_data[TRIES_W-1:0];
                REG_NEW_CYCLE_WAIT: r_new_cycle_wait <= i_cfg_data[COUNT_W-1:0];
                REG_SETTLE:         r_settle         <= i_cfg_data[SECS_W-1:0];
                REG_TOGGLE_WAIT:    r_toggle_wait    <= i_cfg_data[SECS_W-1:0];
                REG_SERVICE_WAIT:   r_service_wait   <= i_cfg_data[SECS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake. The result register loads whenever it is empty or
    // being drained; the input register moves forward whenever the result
    // register loads, and refills in the same cycle.
    logic r_in_valid;
    logic r_reload;
    logic r_service;
    logic r_reply_ok;
    logic r_out_valid;
    logic w_out_load;
    logic w_step;

    assign w_out_load = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_out_load;
    assign i_in.ready = !r_in_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_reload   <= i_in.reload_request;
            r_service  <= i_in.service_mode;
            r_reply_ok <= i_in.at_reply_ok;
        end
    end

    // Sequencer state.
    t_substate r_substate;
    t_count    r_countdown;
    t_tries    r_hard_left;
    t_tries    r_toggle_left;
    t_substate n_substate;
    t_count    n_countdown;
    t_tries    n_hard_left;
    t_tries    n_toggle_left;

    // Decision for the step held in the input register.
    t_power w_power;
    logic   w_pulse;
    logic   w_probe;
    logic   w_clear;
    logic   w_online;
    t_delay w_delay;
    logic   w_count_busy;
    t_count w_count_dec;

    assign w_count_busy = (r_countdown != '0);
    assign w_count_dec  = r_countdown - t_count'(1);

    always_comb begin
        n_substate    = r_substate;
        n_countdown   = r_countdown;
        n_hard_left   = r_hard_left;
        n_toggle_left = r_toggle_left;
        w_power       = PWR_NONE;
        w_pulse       = 1'b0;
        w_probe       = 1'b0;
        w_clear       = 1'b0;
        w_online      = 1'b0;
        w_delay       = DELAY_NONE;
        // A reload step leaves the whole state untouched.
        if (!r_reload) begin
            unique case (r_substate)
                ST_INIT: begin
                    w_delay     = DELAY_PULSE;
                    w_clear     = 1'b1;
                    n_hard_left = r_hard_tries;
                    n_substate  = ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (r_service) begin
                        n_countdown = t_count'(r_service_wait);
                        n_substate  = ST_LONG_WAIT;
                    end else if (r_hard_left != '0) begin
                        w_clear     = 1'b1;
                        n_hard_left = r_hard_left - t_tries'(1);
                        w_power     = PWR_OFF;
                        n_countdown = t_count'(r_settle);
                        n_substate  = ST_AFTER_OFF;
                    end else begin
                        w_power     = PWR_OFF;
                        n_countdown = r_new_cycle_wait;
                        n_substate  = ST_LONG_WAIT;
                    end
                end
                ST_AFTER_OFF: begin
                    if (w_count_busy) begin
                        w_delay     = DELAY_TICK;
                        n_countdown = w_count_dec;
                    end else begin
                        w_power     = PWR_ON;
                        n_countdown = t_count'(r_settle);
                        n_substate  = ST_AFTER_ON;
                    end
                end
                ST_AFTER_ON: begin
                    if (w_count_busy) begin
                        w_delay     = DELAY_TICK;
                        n_countdown = w_count_dec;
                    end else begin
                        n_toggle_left = r_toggle_tries;
                        n_substate    = ST_TOGGLE;
                    end
                end
                ST_TOGGLE: begin
                    if (r_toggle_left != '0) begin
                        n_toggle_left = r_toggle_left - t_tries'(1);
                        w_pulse       = 1'b1;
                        w_delay       = DELAY_PULSE;
                        n_countdown   = t_count'(r_toggle_wait);
                        n_substate    = ST_AFTER_TOGGLE;
                    end else begin
                        n_substate = ST_DECIDE;
                    end
                end
                ST_AFTER_TOGGLE: begin
                    if (w_count_busy) begin
                        w_delay     = DELAY_TICK;
                        n_countdown = w_count_dec;
                    end else begin
                        w_probe    = 1'b1;
                        w_delay    = DELAY_TICK;
                        n_substate = ST_EVALUATE;
                    end
                end
                ST_EVALUATE: begin
                    if (r_reply_ok) begin
                        w_online   = 1'b1;
                        n_substate = ST_INIT;
                    end else begin
                        n_substate = ST_TOGGLE;
                    end
                end
                ST_LONG_WAIT: begin
                    if (w_count_busy) begin
                        w_delay     = DELAY_TICK;
                        n_countdown = w_count_dec;
                    end else begin
                        w_clear     = 1'b1;
                        n_hard_left = r_hard_tries;
                        n_substate  = ST_DECIDE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_substate    <= ST_INIT;
            r_countdown   <= '0;
            r_hard_left   <= '0;
            r_toggle_left <= '0;
        end else if (w_step) begin
            r_substate    <= n_substate;
            r_countdown   <= n_countdown;
            r_hard_left   <= n_hard_left;
            r_toggle_left <= n_toggle_left;
        end
    end

    // Result register.
    t_substate r_res_substate;
    t_power    r_res_power;
    logic      r_res_pulse;
    logic      r_res_probe;
    logic      r_res_clear;
    logic      r_res_reload;
    logic      r_res_online;
    t_delay    r_res_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res_substate <= n_substate;
            r_res_power    <= w_power;
            r_res_pulse    <= w_pulse;
            r_res_probe    <= w_probe;
            r_res_clear    <= w_clear;
            r_res_reload   <= r_reload;
            r_res_online   <= w_online;
            r_res_delay    <= w_delay;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.next_substate   = r_res_substate;
    assign o_out.power_action    = r_res_power;
    assign o_out.switch_pulse    = r_res_pulse;
    assign o_out.send_probe      = r_res_probe;
    assign o_out.clear_link_info = r_res_clear;
    assign o_out.reload_strobe   = r_res_reload;
    assign o_out.online_handover = r_res_online;
    assign o_out.delay_ms        = r_res_delay;

    // A reload result carries no action at all.
    a_reload_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_reload) |->
            (r_res_power == PWR_NONE && !r_res_pulse && !r_res_probe &&
             !r_res_clear && !r_res_online && r_res_delay == DELAY_NONE))
        else $error("reload result carries an action");

    // Handover always sends the sequencer back to its initial substate.
    a_handover_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_online) |-> (r_res_substate == ST_INIT))
        else $error("handover without return to initial substate");

    // At most one modem action is requested per step.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_res_power != PWR_NONE, r_res_pulse,
                                  r_res_probe, r_res_online}))
        else $error("more than one modem action in a step");

    // The state only moves when a step is taken.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_substate) && $stable(r_countdown))
        else $error("sequencer state changed without a step");

endmodule
